[rtl/core/nvfd_pkg.sv]
package nvfd_pkg;

	typedef struct packed {
		logic [7:0] packed_byte;
		logic [7:0] scale_byte;
		logic       last_item;
	} item_t;

	typedef struct packed {
		logic [31:0] value_even;
		logic [31:0] value_odd;
		logic        scale_error;
		logic        last_out;
	} result_t;

	// load enables of the five pipeline registers, s1 first
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} stage_en_t;

	localparam logic [31:0] GSCALE_RESET = 32'h3F80_0000;
	localparam logic [31:0] CANON_NAN    = 32'h7FC0_0000;
	localparam logic [31:0] POS_INF      = 32'h7F80_0000;
	localparam logic [6:0]  SCALE_NAN    = 7'h7F;

endpackage

[rtl/core/nvfd_lane.sv]
module nvfd_lane (
	input  logic               clk,
	input  nvfd_pkg::stage_en_t en,
	input  logic [3:0]         nib,
	input  logic [7:0]         scale_byte,
	input  logic [31:0]        gscale,
	input  logic               bad,
	output logic [31:0]        value
);

	// stage 1: decode operands
	logic [2:0]        a_idx;
	logic [3:0]        a_val;
	logic [3:0]        sv;
	logic [3:0]        sexp;
	logic [7:0]        gfield;
	logic signed [9:0] k;
	logic signed [9:0] gexp;
	logic [23:0]       gm;

	logic [7:0]        prod_s1;
	logic [23:0]       gm_s1;
	logic signed [9:0] e_s1;
	logic              sign_s1, nan_s1, bad_s1;

	always_comb begin
		a_idx = nib[2:0];
		unique case (a_idx)
			3'd0: a_val = 4'd0;
			3'd1: a_val = 4'd1;
			3'd2: a_val = 4'd2;
			3'd3: a_val = 4'd3;
			3'd4: a_val = 4'd4;
			3'd5: a_val = 4'd6;
			3'd6: a_val = 4'd8;
			default: a_val = 4'd12;
		endcase
		sexp   = scale_byte[6:3];
		gfield = gscale[30:23];
		if (sexp == 4'd0) begin
			sv = {1'b0, scale_byte[2:0]};
			k  = -10'sd10;
		end else begin
			sv = {1'b1, scale_byte[2:0]};
			k  = $signed({6'd0, sexp}) - 10'sd11;
		end
		if (gfield == 8'd0) begin
			gm   = {1'b0, gscale[22:0]};
			gexp = -10'sd149;
		end else begin
			gm   = {1'b1, gscale[22:0]};
			gexp = $signed({2'd0, gfield}) - 10'sd150;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			prod_s1 <= a_val * sv;
			gm_s1   <= gm;
			e_s1    <= k + gexp;
			sign_s1 <= nib[3] ^ scale_byte[7] ^ gscale[31];
			nan_s1  <= scale_byte[6:0] == nvfd_pkg::SCALE_NAN;
			bad_s1  <= bad;
		end
	end

	// stage 2: full product
	logic [31:0]       n_s2;
	logic signed [9:0] e_s2;
	logic              sign_s2, nan_s2, bad_s2;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			n_s2    <= prod_s1 * gm_s1;
			e_s2    <= e_s1;
			sign_s2 <= sign_s1;
			nan_s2  <= nan_s1;
			bad_s2  <= bad_s1;
		end
	end

	// stage 3: find leading one and the alignment shift
	logic [4:0]        p;
	logic signed [9:0] sa, sb;
	logic [31:0]       n_s3;
	logic signed [9:0] s_s3, e_s3;
	logic              sign_s3, nan_s3, bad_s3, zero_s3;

	always_comb begin
		p = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (n_s2[i]) p = 5'(i);
		end
		sa = $signed({5'd0, p}) - 10'sd23;
		sb = -10'sd149 - e_s2;
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			n_s3    <= n_s2;
			s_s3    <= (sa > sb) ? sa : sb;
			e_s3    <= e_s2;
			sign_s3 <= sign_s2;
			nan_s3  <= nan_s2;
			bad_s3  <= bad_s2;
			zero_s3 <= n_s2 == 32'd0;
		end
	end

	// stage 4: shift and round to nearest even
	logic [4:0]        ls;
	logic [5:0]        rs;
	logic [55:0]       lsh;
	logic [64:0]       rsh;
	logic              up;
	logic [24:0]       q;
	logic signed [9:0] s_adj;
	logic [23:0]       q_s4;
	logic signed [9:0] s_s4, e_s4;
	logic              sign_s4, nan_s4, bad_s4, zero_s4;

	always_comb begin
		ls  = 5'(-s_s3);
		rs  = (s_s3 > 10'sd33) ? 6'd33 : 6'(s_s3);
		lsh = {24'd0, n_s3} << ls;
		rsh = {n_s3, 33'd0} >> rs;
		up  = rsh[32] && ((|rsh[31:0]) || rsh[33]);
		if (s_s3 <= 10'sd0) q = lsh[24:0];
		else q = {1'b0, rsh[56:33]} + {24'd0, up};
		s_adj = s_s3;
		if (q[24]) begin
			q     = q >> 1;
			s_adj = s_s3 + 10'sd1;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			q_s4    <= q[23:0];
			s_s4    <= s_adj;
			e_s4    <= e_s3;
			sign_s4 <= sign_s3;
			nan_s4  <= nan_s3;
			bad_s4  <= bad_s3;
			zero_s4 <= zero_s3;
		end
	end

	// stage 5: pack fp32 and apply special cases
	logic signed [10:0] field;
	logic [31:0]        packed_val;

	always_comb begin
		field = {e_s4[9], e_s4} + {s_s4[9], s_s4} + 11'sd150;
		if (bad_s4) packed_val = 32'd0;
		else if (nan_s4) packed_val = nvfd_pkg::CANON_NAN;
		else if (zero_s4) packed_val = {sign_s4, 31'd0};
		else if (!q_s4[23]) packed_val = {sign_s4, 8'd0, q_s4[22:0]};
		else if (field >= 11'sd255) packed_val = {sign_s4, nvfd_pkg::POS_INF[30:0]};
		else packed_val = {sign_s4, field[7:0], q_s4[22:0]};
	end

	always_ff @(posedge clk) begin
		if (en.s5) value <= packed_val;
	end

endmodule

[rtl/core/nvfp4_weight_dequantizer.sv]
// Items pass the pipeline registers s1 to s5 in order. Throughput: one item
// per cycle unless result_stall backs up a full pipeline; five pipeline
// registers, each with its own load enable, so an empty stage fills even
// while the output is stalled.
// Reset (arst_n, asynchronous, active low) clears all stage valid bits and
// sets the global scale to 1.0.
module nvfp4_weight_dequantizer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [31:0]       cfg_data,
	input  logic              item_valid,
	output logic              item_stall,
	input  nvfd_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output nvfd_pkg::result_t result
);

	logic [31:0]         gscale_q;
	logic                bad;
	logic [4:0]          v_q;
	nvfd_pkg::stage_en_t en;
	logic [4:0]          last_q, bad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) gscale_q <= nvfd_pkg::GSCALE_RESET;
		else if (cfg_we) gscale_q <= cfg_data;
	end

	assign bad = (gscale_q[30:23] == 8'hFF) || (gscale_q[31] && (gscale_q[30:0] != 31'd0));

	// a stage loads when it is empty or the next one moves
	always_comb begin
		en.s5 = !v_q[4] || !result_stall;
		en.s4 = !v_q[3] || en.s5;
		en.s3 = !v_q[2] || en.s4;
		en.s2 = !v_q[1] || en.s3;
		en.s1 = !v_q[0] || en.s2;
	end

	assign item_stall = !en.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 5'd0;
		end else begin
			if (en.s1) v_q[0] <= item_valid;
			if (en.s2) v_q[1] <= v_q[0];
			if (en.s3) v_q[2] <= v_q[1];
			if (en.s4) v_q[3] <= v_q[2];
			if (en.s5) v_q[4] <= v_q[3];
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			last_q[0] <= item.last_item;
			bad_q[0]  <= bad;
		end
		if (en.s2) begin
			last_q[1] <= last_q[0];
			bad_q[1]  <= bad_q[0];
		end
		if (en.s3) begin
			last_q[2] <= last_q[1];
			bad_q[2]  <= bad_q[1];
		end
		if (en.s4) begin
			last_q[3] <= last_q[2];
			bad_q[3]  <= bad_q[2];
		end
		if (en.s5) begin
			last_q[4] <= last_q[3];
			bad_q[4]  <= bad_q[3];
		end
	end

	nvfd_lane u_even (
		.clk        (clk),
		.en         (en),
		.nib        (item.packed_byte[3:0]),
		.scale_byte (item.scale_byte),
		.gscale     (gscale_q),
		.bad        (bad),
		.value      (result.value_even)
	);

	nvfd_lane u_odd (
		.clk        (clk),
		.en         (en),
		.nib        (item.packed_byte[7:4]),
		.scale_byte (item.scale_byte),
		.gscale     (gscale_q),
		.bad        (bad),
		.value      (result.value_odd)
	);

	assign result.scale_error = bad_q[4];
	assign result.last_out    = last_q[4];
	assign result_valid       = v_q[4];

`ifndef SYNTHESIS
	a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (result_valid && result_stall))
		else $error("input stalled while output is free");

	a_bad_gives_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.scale_error) |->
			(result.value_even == 32'd0 && result.value_odd == 32'd0))
		else $error("bad global scale with nonzero values");

	a_nan_canonical: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.value_even[30:23] == 8'hFF &&
			result.value_even[22:0] != 23'd0) |->
			(result.value_even == nvfd_pkg::CANON_NAN))
		else $error("non-canonical NaN on even value");
`endif

endmodule

[verif/dequant_checker.sv]
module dequant_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [31:0]       cfg_data,
	input  logic              item_valid,
	input  logic              item_stall,
	input  nvfd_pkg::item_t   item,
	input  logic              result_valid,
	input  logic              result_stall,
	input  nvfd_pkg::result_t result,
	output int                fail_count,
	output int                pending,
	output int                results_seen
);

	logic [31:0] gscale;
	nvfd_pkg::result_t expected_q[$];

	function automatic logic [31:0] round_fp32(logic sign, logic [63:0] n, int e);
		int p, s, field;
		logic [63:0] q, rem, half;
		p = 0;
		for (int i = 0; i < 64; i++)
			if (n[i]) p = i;
		s = p - 23;
		if (-149 - e > s) s = -149 - e;
		if (s <= 0) begin
			q = n << (-s);
		end else if (s > 63) begin
			q = 0;
			if (s == 64 && n > 64'h8000_0000_0000_0000) q = 1;
		end else begin
			q = n >> s;
			rem = n & ((64'd1 << s) - 64'd1);
			half = 64'd1 << (s - 1);
			if (rem > half || (rem == half && q[0])) q++;
		end
		if (q >= (64'd1 << 24)) begin
			q >>= 1;
			s++;
		end
		if (q < (64'd1 << 23)) return {sign, q[30:0]};
		field = e + s + 150;
		if (field >= 255) return {sign, 31'h7F80_0000};
		return {sign, field[7:0], q[22:0]};
	endfunction

	function automatic logic [31:0] scale_weight(logic [3:0] nib, logic [7:0] sc,
			logic [31:0] g);
		logic [3:0] halves;
		logic [3:0] sv;
		logic [23:0] gm;
		logic [63:0] n;
		logic sign;
		int k, gexp;
		sign = nib[3] ^ sc[7] ^ g[31];
		case (nib[2:0])
			3'd5: halves = 4'd6;
			3'd6: halves = 4'd8;
			3'd7: halves = 4'd12;
			default: halves = {1'b0, nib[2:0]};
		endcase
		if (sc[6:0] == nvfd_pkg::SCALE_NAN) return nvfd_pkg::CANON_NAN;
		if (sc[6:3] == 0) begin
			sv = {1'b0, sc[2:0]};
			k = -10;
		end else begin
			sv = {1'b1, sc[2:0]};
			k = int'(sc[6:3]) - 11;
		end
		if (g[30:23] == 0) begin
			gm = {1'b0, g[22:0]};
			gexp = -149;
		end else begin
			gm = {1'b1, g[22:0]};
			gexp = int'(g[30:23]) - 150;
		end
		n = 64'(halves) * 64'(sv) * 64'(gm);
		if (n == 0) return {sign, 31'd0};
		return round_fp32(sign, n, k + gexp);
	endfunction

	function automatic nvfd_pkg::result_t dequant_item(nvfd_pkg::item_t it, logic [31:0] g);
		nvfd_pkg::result_t r;
		logic bad;
		bad = (g[30:23] == 8'hFF) || (g[31] && g[30:0] != 0);
		r.value_even = bad ? 32'd0 : scale_weight(it.packed_byte[3:0], it.scale_byte, g);
		r.value_odd = bad ? 32'd0 : scale_weight(it.packed_byte[7:4], it.scale_byte, g);
		r.scale_error = bad;
		r.last_out = it.last_item;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		fail_count++;
	endtask

	assign pending = expected_q.size();

	initial begin
		fail_count = 0;
		results_seen = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		nvfd_pkg::result_t want;
		if (!arst_n) begin
			gscale <= nvfd_pkg::GSCALE_RESET;
			expected_q.delete();
		end else begin
			if (cfg_we) gscale <= cfg_data;
			if (item_valid && !item_stall) expected_q.push_back(dequant_item(item, gscale));
			if (result_valid && !result_stall) begin
				results_seen++;
				if (expected_q.size() == 0) begin
					report_mismatch("unexpected result", 0, 0);
				end else begin
					want = expected_q.pop_front();
					if (result.value_even !== want.value_even)
						report_mismatch("value_even", result.value_even, want.value_even);
					if (result.value_odd !== want.value_odd)
						report_mismatch("value_odd", result.value_odd, want.value_odd);
					if (result.scale_error !== want.scale_error)
						report_mismatch("scale_error", result.scale_error, want.scale_error);
					if (result.last_out !== want.last_out)
						report_mismatch("last_out", result.last_out, want.last_out);
				end
			end
		end
	end
endmodule

[verif/tb_top.sv]
module tb_top;

	localparam int CYCLE_LIMIT = 200000;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [31:0] cfg_data = 0;
	logic item_valid = 0;
	logic item_stall;
	nvfd_pkg::item_t item = '0;
	logic result_valid;
	logic result_stall = 0;
	nvfd_pkg::result_t result;
	int fail_count, pending, results_seen;
	int cycles = 0;
	int sent = 0;
	bit calm = 0;
	bit hold_off = 0;

	always #1 clk = ~clk;

	nvfp4_weight_dequantizer dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result)
	);

	dequant_checker chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.fail_count(fail_count), .pending(pending), .results_seen(results_seen)
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// receiver: random stall, none while calm, solid while held off
	always @(negedge clk)
		result_stall <= hold_off || (!calm && $urandom_range(99) < 14);

	// valid stays high into the next transfer; drop it only on an idle cycle
	task automatic send_item(logic [7:0] pb, logic [7:0] sc, logic last);
		while (!calm && $urandom_range(99) < 14) begin
			item_valid <= 0;
			@(negedge clk);
		end
		item_valid <= 1;
		item <= '{packed_byte: pb, scale_byte: sc, last_item: last};
		@(posedge clk);
		while (item_stall) @(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	task automatic drain_and_write(logic [31:0] g);
		item_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		cfg_we <= 1;
		cfg_data <= g;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	function automatic logic [31:0] random_gscale();
		case ($urandom_range(9))
			0: return $urandom();
			1: return {1'b0, 8'($urandom_range(0, 3)), 23'($urandom())};
			2: return {1'b0, 8'($urandom_range(240, 254)), 23'($urandom())};
			3: return {1'b1, 31'($urandom())};
			default: return {1'b0, 8'($urandom_range(100, 150)), 23'($urandom())};
		endcase
	endfunction

	logic [31:0] gscales[10] = '{32'h3F80_0000, 32'h0000_0001, 32'h7F7F_FFFF,
		32'h8000_0000, 32'h0000_0000, 32'h7F80_0000, 32'h7FC0_0001, 32'hBF80_0000,
		32'h007F_FFFF, 32'h3E2A_AAAB};

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		// directed: every code, both nibbles, at reset scale
		for (int i = 0; i < 16; i++) send_item({4'(15 - i), 4'(i)}, 8'(i * 17), i == 15);
		send_item(8'hFF, 8'h7F, 0);
		send_item(8'h77, 8'hFF, 0);
		send_item(8'h88, 8'h7E, 0);
		send_item(8'h70, 8'h01, 1);
		foreach (gscales[j]) begin
			drain_and_write(gscales[j]);
			for (int i = 0; i < 8; i++)
				send_item(8'($urandom()), 8'($urandom()), 1'($urandom_range(1)));
		end
		// random phases over random global scales
		for (int ph = 0; ph < 20; ph++) begin
			drain_and_write(ph == 0 ? 32'h3F80_0000 : random_gscale());
			calm = (ph == 5);
			if (ph == 8) fork
				begin
					hold_off = 1;
					repeat (60) @(negedge clk);
					hold_off = 0;
				end
			join_none
			for (int i = 0; i < 90; i++)
				send_item(8'($urandom()),
					($urandom_range(9) == 0) ? {1'($urandom_range(1)), 7'h7F}
					: 8'($urandom()), $urandom_range(15) == 0);
			if (ph == 12) begin
				item_valid <= 0;
				while (pending != 0) @(negedge clk);
			end
		end
		calm = 0;
		item_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		$display("sent %0d items, checked %0d results over 31 global scale settings",
			sent, results_seen);
		$display("including zero, subnormal, max, inf, NaN and negative scales");
		if (fail_count == 0 && pending == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end
endmodule
